[hdl/dfst_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfst_pkg
// shared types, constants and the sequencer program for the depth-first
// search timestamp block
// ----------------------------------------------------------------------------
package dfst_pkg;

  // default graph size
  localparam int DFST_MAX_VERTICES = 64;

  // fixed field widths
  localparam int ROW_W  = 64;
  localparam int VTX_W  = 6;
  localparam int TIME_W = 8;
  localparam int CFG_W  = 7;
  localparam int STEP_W = 4;

  // item opcodes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef struct packed {
    logic             op;
    logic [VTX_W-1:0] row_index;
    logic [ROW_W-1:0] row_bits;
  } in_item_t;

  typedef struct packed {
    logic [VTX_W-1:0]  vertex;
    logic [TIME_W-1:0] discover_time;
    logic [TIME_W-1:0] finish_time;
    logic              is_last;
  } out_item_t;

  // jump conditions
  typedef enum logic [2:0] {
    C_FALL       = 3'd0,
    C_ALWAYS     = 3'd1,
    C_NO_SEARCH  = 3'd2,
    C_ROOTS_DONE = 3'd3,
    C_NOT_WHITE  = 3'd4,
    C_NO_CAND    = 3'd5,
    C_STACK_LAST = 3'd6,
    C_NOT_LAST   = 3'd7
  } cond_t;

  // program addresses
  localparam logic [STEP_W-1:0] S_IDLE       = 4'd0;
  localparam logic [STEP_W-1:0] S_INIT       = 4'd1;
  localparam logic [STEP_W-1:0] S_ROOT_TEST  = 4'd2;
  localparam logic [STEP_W-1:0] S_ROOT_CHK   = 4'd3;
  localparam logic [STEP_W-1:0] S_ROOT_PUSH  = 4'd4;
  localparam logic [STEP_W-1:0] S_ADJ_RD     = 4'd5;
  localparam logic [STEP_W-1:0] S_SCAN       = 4'd6;
  localparam logic [STEP_W-1:0] S_PUSH       = 4'd7;
  localparam logic [STEP_W-1:0] S_POP        = 4'd8;
  localparam logic [STEP_W-1:0] S_POP_LOAD   = 4'd9;
  localparam logic [STEP_W-1:0] S_ROOT_ADV   = 4'd10;
  localparam logic [STEP_W-1:0] S_EMIT_SETUP = 4'd11;
  localparam logic [STEP_W-1:0] S_EMIT_RD    = 4'd12;
  localparam logic [STEP_W-1:0] S_EMIT_OUT   = 4'd13;
  localparam logic [STEP_W-1:0] S_DONE       = 4'd14;

  typedef struct packed {
    cond_t             cond;
    logic [STEP_W-1:0] tgt;
    logic              init;      // whiten all, time to one, empty stack
    logic              push;      // discover a vertex and push it
    logic              push_root; // push source is the root index
    logic              pop;       // finish top of stack and pop
    logic              idx_clr;
    logic              idx_inc;
    logic              adj_rd;    // read adjacency row of top of stack
    logic              load_u;    // new top of stack from stack read
    logic              emit_rd;   // read both timestamps of index
    logic              emit_out;
  } ctrl_word_t;

  function automatic ctrl_word_t dfst_ucode(input logic [STEP_W-1:0] step);
    ctrl_word_t cw;
    cw = '0;
    cw.cond = C_FALL;
    cw.tgt  = S_IDLE;
    case (step)
      S_IDLE: begin
        cw.cond = C_NO_SEARCH;
        cw.tgt  = S_IDLE;
      end
      S_INIT: begin
        cw.init    = 1'b1;
        cw.idx_clr = 1'b1;
      end
      S_ROOT_TEST: begin
        cw.cond = C_ROOTS_DONE;
        cw.tgt  = S_EMIT_SETUP;
      end
      S_ROOT_CHK: begin
        cw.cond = C_NOT_WHITE;
        cw.tgt  = S_ROOT_ADV;
      end
      S_ROOT_PUSH: begin
        cw.push      = 1'b1;
        cw.push_root = 1'b1;
      end
      S_ADJ_RD: begin
        cw.adj_rd = 1'b1;
      end
      S_SCAN: begin
        cw.cond = C_NO_CAND;
        cw.tgt  = S_POP;
      end
      S_PUSH: begin
        cw.push = 1'b1;
        cw.cond = C_ALWAYS;
        cw.tgt  = S_ADJ_RD;
      end
      S_POP: begin
        cw.pop  = 1'b1;
        cw.cond = C_STACK_LAST;
        cw.tgt  = S_ROOT_ADV;
      end
      S_POP_LOAD: begin
        cw.load_u = 1'b1;
        cw.cond   = C_ALWAYS;
        cw.tgt    = S_ADJ_RD;
      end
      S_ROOT_ADV: begin
        cw.idx_inc = 1'b1;
        cw.cond    = C_ALWAYS;
        cw.tgt     = S_ROOT_TEST;
      end
      S_EMIT_SETUP: begin
        cw.idx_clr = 1'b1;
      end
      S_EMIT_RD: begin
        cw.emit_rd = 1'b1;
      end
      S_EMIT_OUT: begin
        cw.emit_out = 1'b1;
        cw.idx_inc  = 1'b1;
        cw.cond     = C_NOT_LAST;
        cw.tgt      = S_EMIT_RD;
      end
      S_DONE: begin
        cw.cond = C_ALWAYS;
        cw.tgt  = S_IDLE;
      end
      default: begin
        cw.cond = C_ALWAYS;
        cw.tgt  = S_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

[hdl/dfs_discovery_finish_times_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_discovery_finish_times_top
// depth-first search discovery and finish timestamps over a loaded digraph
// ----------------------------------------------------------------------------
// usage: an item is taken when start is high and busy is low. a load item
// (op 0) writes one adjacency row in that single cycle and busy stays low
// (a row index at or above vertex_count is dropped). a search item (op 1)
// raises busy, walks the graph roots first in index order, always to the
// lowest-numbered white neighbor, then presents one result per vertex in
// index order, each for exactly one cycle under out_valid; the last one
// carries is_last. results cannot be held off, so the receiver must take
// every out_valid cycle. the sequencer takes one step per cycle, and the
// adjacency store has a single read port whose row is registered before
// each neighbor scan. vertex_count is written through cfg_we/cfg_wdata;
// the user must write it only while busy is low, which the block itself
// does not enforce; 0 is taken as 1 and values above MAX_VERTICES as
// MAX_VERTICES.
// ----------------------------------------------------------------------------
module dfs_discovery_finish_times_top
  import dfst_pkg::*;
#(
  parameter int MAX_VERTICES = DFST_MAX_VERTICES
) (
  input  logic             clk,
  input  logic             rst_n,
  // item channel
  input  logic             start,
  output logic             busy,
  input  in_item_t         in_data,
  // result channel
  output logic             out_valid,
  output out_item_t        out_data,
  // vertex_count register
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int VIDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);

  // sequencer
  logic [STEP_W-1:0] step_r, step_nxt;
  ctrl_word_t        cw;
  logic              cond_hit;

  // datapath control state
  logic [CFG_W-1:0]        n_r;
  logic [TIME_W-1:0]       time_r;
  logic [CNT_W-1:0]        sp_r;
  logic [CNT_W-1:0]        idx_r;
  logic [VIDX_W-1:0]       u_r;
  logic [MAX_VERTICES-1:0] white_r;
  logic [MAX_VERTICES-1:0] adj_vld_r;
  logic                    out_valid_r;

  // stores and their registered read data
  logic [ROW_W-1:0]  adj_mem  [MAX_VERTICES];
  logic [TIME_W-1:0] disc_mem [MAX_VERTICES];
  logic [TIME_W-1:0] fin_mem  [MAX_VERTICES];
  logic [VIDX_W-1:0] stk_mem  [MAX_VERTICES];
  logic [ROW_W-1:0]  adj_q_r;
  logic              adj_vq_r;
  logic [TIME_W-1:0] disc_q_r;
  logic [TIME_W-1:0] fin_q_r;
  logic [VIDX_W-1:0] stk_q_r;
  out_item_t         out_data_r;

  // combinational helpers
  logic [VIDX_W-1:0]       idx_v;
  logic [CNT_W-1:0]        sp_m2;
  logic [MAX_VERTICES-1:0] vmask;
  logic [MAX_VERTICES-1:0] cand;
  logic [MAX_VERTICES-1:0] iso;
  logic [VIDX_W-1:0]       nxt_v;
  logic [VIDX_W-1:0]       push_v;
  logic                    last_vtx;
  logic                    load_en;
  logic [CFG_W-1:0]        cfg_clamped;

  assign busy = (step_r != S_IDLE);
  assign cw   = dfst_ucode(step_r);

  assign idx_v    = idx_r[VIDX_W-1:0];
  assign sp_m2    = sp_r - CNT_W'(2);
  assign last_vtx = (CFG_W'(idx_r) == (n_r - CFG_W'(1)));

  // row loads land straight from the idle step
  assign load_en = start && !busy && (in_data.op == OP_LOAD) &&
                   (CFG_W'(in_data.row_index) < n_r);

  // clamp of the written vertex count
  always_comb begin
    cfg_clamped = cfg_wdata;
    if (cfg_wdata == '0) begin
      cfg_clamped = CFG_W'(1);
    end else if (cfg_wdata > CFG_W'(MAX_VERTICES)) begin
      cfg_clamped = CFG_W'(MAX_VERTICES);
    end
  end

  // neighbor lanes: edge present, vertex in use and still white
  always_comb begin
    for (int j = 0; j < MAX_VERTICES; j++) begin
      vmask[j] = (CFG_W'(j) < n_r);
    end
    cand = (adj_vq_r ? adj_q_r[MAX_VERTICES-1:0] : '0) & white_r & vmask;
    // isolate the lowest candidate, then encode it
    iso   = cand & (~cand + MAX_VERTICES'(1));
    nxt_v = '0;
    for (int j = 0; j < MAX_VERTICES; j++) begin
      if (iso[j]) begin
        nxt_v = nxt_v | VIDX_W'(j);
      end
    end
  end

  // a root push takes the root index, a tree push the found neighbor
  assign push_v = cw.push_root ? idx_v : nxt_v;

  // jump condition select
  always_comb begin
    case (cw.cond)
      C_FALL:       cond_hit = 1'b0;
      C_ALWAYS:     cond_hit = 1'b1;
      C_NO_SEARCH:  cond_hit = !(start && (in_data.op == OP_SEARCH));
      C_ROOTS_DONE: cond_hit = (CFG_W'(idx_r) >= n_r);
      C_NOT_WHITE:  cond_hit = !white_r[idx_v];
      C_NO_CAND:    cond_hit = (cand == '0);
      C_STACK_LAST: cond_hit = (sp_r == CNT_W'(1));
      C_NOT_LAST:   cond_hit = !last_vtx;
      default:      cond_hit = 1'b1;
    endcase
    step_nxt = cond_hit ? cw.tgt : (step_r + STEP_W'(1));
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= S_IDLE;
      n_r         <= CFG_W'(MAX_VERTICES);
      time_r      <= TIME_W'(1);
      sp_r        <= '0;
      idx_r       <= '0;
      u_r         <= '0;
      white_r     <= '1;
      adj_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= cw.emit_out;
      if (cfg_we) begin
        n_r <= cfg_clamped;
      end
      if (load_en) begin
        adj_vld_r[in_data.row_index[VIDX_W-1:0]] <= 1'b1;
      end
      if (cw.init) begin
        white_r <= '1;
        time_r  <= TIME_W'(1);
        sp_r    <= '0;
      end
      if (cw.idx_clr) begin
        idx_r <= '0;
      end else if (cw.idx_inc) begin
        idx_r <= idx_r + CNT_W'(1);
      end
      if (cw.push) begin
        white_r[push_v] <= 1'b0;
        time_r          <= time_r + TIME_W'(1);
        sp_r            <= sp_r + CNT_W'(1);
        u_r             <= push_v;
      end
      if (cw.pop) begin
        time_r <= time_r + TIME_W'(1);
        sp_r   <= sp_r - CNT_W'(1);
      end
      if (cw.load_u) begin
        u_r <= stk_q_r;
      end
    end
  end

  // adjacency store, row valid bits stand in for the zero reset
  always_ff @(posedge clk) begin
    if (load_en) begin
      adj_mem[in_data.row_index[VIDX_W-1:0]] <= in_data.row_bits;
    end
    if (cw.adj_rd) begin
      adj_q_r  <= adj_mem[u_r];
      adj_vq_r <= adj_vld_r[u_r];
    end
  end

  // discovery times
  always_ff @(posedge clk) begin
    if (cw.push) begin
      disc_mem[push_v] <= time_r;
    end
    if (cw.emit_rd) begin
      disc_q_r <= disc_mem[idx_v];
    end
  end

  // finish times
  always_ff @(posedge clk) begin
    if (cw.pop) begin
      fin_mem[u_r] <= time_r;
    end
    if (cw.emit_rd) begin
      fin_q_r <= fin_mem[idx_v];
    end
  end

  // vertex stack, next top read while popping
  always_ff @(posedge clk) begin
    if (cw.push) begin
      stk_mem[sp_r[VIDX_W-1:0]] <= push_v;
    end
    if (cw.pop) begin
      stk_q_r <= stk_mem[sp_m2[VIDX_W-1:0]];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cw.emit_out) begin
      out_data_r.vertex        <= VTX_W'(idx_v);
      out_data_r.discover_time <= disc_q_r;
      out_data_r.finish_time   <= fin_q_r;
      out_data_r.is_last       <= last_vtx;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hdl/dfst_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfst_chk
// port-level checks of the depth-first search timestamp block
// ----------------------------------------------------------------------------
module dfst_chk
  import dfst_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input in_item_t         in_data,
  input logic             out_valid,
  input out_item_t        out_data,
  input logic             cfg_we
);

  // results only come out of a running search
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result item outside a search");

  // a search item raises busy
  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.op == OP_SEARCH) |=> busy)
    else $error("search item did not start a run");

  // a load item finishes in its own cycle
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.op == OP_LOAD && !cfg_we) |=> !busy)
    else $error("row load held the block busy");

  // results follow in vertex order, with out_valid low between them
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.is_last) |=> !out_valid ##1
      (out_valid && out_data.vertex == $past(out_data.vertex, 2) + 6'd1))
    else $error("result items out of order");

  // a vertex is finished after it is discovered
  a_time_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.discover_time != '0 &&
                   out_data.discover_time < out_data.finish_time))
    else $error("finish time not after discovery time");

endmodule

bind dfs_discovery_finish_times_top dfst_chk u_dfst_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data),
  .cfg_we    (cfg_we)
);

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the depth-first search timestamp block: loads
// adjacency rows, runs searches over graphs of many sizes and shapes, and
// checks every emitted vertex result against a local timestamp predictor
// ----------------------------------------------------------------------------
module tb_top;
  import dfst_pkg::*;

  localparam int     CLK_HALF_NS   = 6;
  localparam int     RESET_CYCLES  = 10;
  localparam int     ITEM_TARGET   = 370;
  // the block can still be closing a search after the last result, so
  // idle checks wait this long on top
  localparam int     SETTLE_CYCLES = 8;
  localparam int     DRAIN_CYCLES  = 50;
  localparam longint LIMIT_NS      = 20_000_000;

  // vertex colors used by the local search
  typedef enum logic [1:0] {
    V_WHITE = 2'd0,
    V_GRAY  = 2'd1,
    V_BLACK = 2'd2
  } vcolor_t;

  // graph shapes for the random phases
  typedef enum int {
    SHAPE_CHAIN,
    SHAPE_SPARSE,
    SHAPE_DENSE,
    SHAPE_TREE,
    SHAPE_BACK
  } shape_t;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             start     = 1'b0;
  in_item_t         in_data   = '0;
  logic             cfg_we    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             busy;
  logic             out_valid;
  out_item_t        out_data;

  // local copy of the block state: adjacency store and vertex count
  logic [ROW_W-1:0] adj_model [DFST_MAX_VERTICES];
  int unsigned      vcount_model;

  // vertex results still owed by the block, oldest first
  out_item_t stamps_due [$];
  out_item_t stamp_want;

  int items_sent     = 0;
  int mismatch_count = 0;

  dfs_discovery_finish_times_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #(CLK_HALF_NS) clk = ~clk;

  // --------------------------------------------------------------------------
  // timestamp predictor
  // --------------------------------------------------------------------------

  // iterative search with an explicit stack: roots in index order, lowest
  // white neighbor first, one tick counter for both stamps starting at 1
  task automatic predict_timestamps();
    vcolor_t           color    [DFST_MAX_VERTICES];
    logic [VTX_W-1:0]  dfs_stack [DFST_MAX_VERTICES];
    logic [TIME_W-1:0] disc     [DFST_MAX_VERTICES];
    logic [TIME_W-1:0] fin      [DFST_MAX_VERTICES];
    logic [TIME_W-1:0] tick;
    int                depth;
    int                u;
    int                nxt;
    bit                found;
    out_item_t         res;
    for (int i = 0; i < DFST_MAX_VERTICES; i++) color[i] = V_WHITE;
    tick = 8'd1;
    for (int r = 0; r < vcount_model; r++) begin
      if (color[r] != V_WHITE) continue;
      dfs_stack[0] = VTX_W'(r);
      depth = 1;
      color[r] = V_GRAY;
      disc[r] = tick;
      tick++;
      while (depth > 0) begin
        u = int'(dfs_stack[depth-1]);
        found = 1'b0;
        nxt = 0;
        // self loops and back edges fall out here: those targets are not white
        for (int j = 0; j < vcount_model; j++) begin
          if (!found && adj_model[u][j] && color[j] == V_WHITE) begin
            nxt = j;
            found = 1'b1;
          end
        end
        if (found && depth < DFST_MAX_VERTICES) begin
          color[nxt] = V_GRAY;
          disc[nxt] = tick;
          tick++;
          dfs_stack[depth] = VTX_W'(nxt);
          depth++;
        end else begin
          depth--;
          color[u] = V_BLACK;
          fin[u] = tick;
          tick++;
        end
      end
    end
    // one result per vertex in index order, last flag on the final one
    for (int i = 0; i < vcount_model; i++) begin
      res.vertex        = VTX_W'(i);
      res.discover_time = disc[i];
      res.finish_time   = fin[i];
      res.is_last       = (i == vcount_model - 1);
      stamps_due.push_back(res);
    end
  endtask

  // --------------------------------------------------------------------------
  // item helpers
  // --------------------------------------------------------------------------

  function automatic logic [ROW_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic in_item_t row_item(int idx, logic [ROW_W-1:0] bits);
    in_item_t it;
    it.op        = OP_LOAD;
    it.row_index = VTX_W'(idx);
    it.row_bits  = bits;
    return it;
  endfunction

  // row and bits are don't-care on a search, so they get random content
  function automatic in_item_t search_item();
    in_item_t it;
    it.op        = OP_SEARCH;
    it.row_index = VTX_W'($urandom_range(0, DFST_MAX_VERTICES - 1));
    it.row_bits  = rand64();
    return it;
  endfunction

  // bits at or above n are stored but never followed, so they carry noise
  function automatic logic [ROW_W-1:0] make_row(shape_t shape, int r, int n);
    logic [ROW_W-1:0] low_mask;
    logic [ROW_W-1:0] bits;
    low_mask = (n >= ROW_W) ? '1 : ((64'd1 << n) - 64'd1);
    case (shape)
      SHAPE_CHAIN:  bits = (64'd1 << (r + 1));
      SHAPE_SPARSE: bits = rand64() & rand64() & rand64();
      SHAPE_DENSE:  bits = rand64() | rand64();
      SHAPE_TREE:   bits = (64'd1 << (2 * r + 1)) | (64'd1 << (2 * r + 2));
      // edges only to itself and lower vertices
      default:      bits = rand64() & ((64'd1 << (r + 1)) - 64'd1);
    endcase
    return (bits & low_mask) | (rand64() & ~low_mask);
  endfunction

  // hold start for one item until an edge finds busy low; start is left
  // high so a following item can go out with no gap
  task automatic send_item(input in_item_t item);
    start   <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    if (item.op == OP_SEARCH) begin
      predict_timestamps();
      items_sent++;
    end else if (item.row_index < vcount_model) begin
      adj_model[item.row_index] = item.row_bits;
      items_sent++;
    end
  endtask

  // random sender gap: mostly none or short, a few long
  task automatic idle_gap(input bit allow);
    int k;
    int len;
    k = $urandom_range(0, 99);
    if (!allow || k < 40) len = 0;
    else if (k < 85) len = $urandom_range(1, 3);
    else if (k < 97) len = $urandom_range(4, 15);
    else len = $urandom_range(20, 60);
    if (len > 0) begin
      start <= 1'b0;
      repeat (len) @(posedge clk);
    end
  endtask

  // block idle: nothing owed, busy low, and a few settle cycles
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (stamps_due.size() != 0 || busy !== 1'b0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // 0 reads as 1 and anything above the maximum as the maximum
  task automatic write_vertex_count(input logic [CFG_W-1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (value == 0) vcount_model = 1;
    else if (value > DFST_MAX_VERTICES) vcount_model = DFST_MAX_VERTICES;
    else vcount_model = 32'(value);
  endtask

  // --------------------------------------------------------------------------
  // result checker: every out_valid cycle must be taken
  // --------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                             input logic [TIME_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (stamps_due.size() == 0) begin
        $display("%0t ns: result with none due, expected none, actual %p", $time, out_data);
        mismatch_count++;
      end else begin
        stamp_want = stamps_due.pop_front();
        check_field("vertex", TIME_W'(stamp_want.vertex), TIME_W'(out_data.vertex));
        check_field("discover_time", stamp_want.discover_time, out_data.discover_time);
        check_field("finish_time", stamp_want.finish_time, out_data.finish_time);
        check_field("is_last", TIME_W'(stamp_want.is_last), TIME_W'(out_data.is_last));
      end
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // reset store is empty and the count is at the maximum: 64 isolated roots
  task automatic test_reset_graph();
    send_item(search_item());
  endtask

  // out-of-range counts clamp to one vertex and to the maximum
  task automatic test_count_clamp();
    write_vertex_count(7'd0);
    send_item(search_item());
    write_vertex_count(7'd127);
    send_item(search_item());
  endtask

  // self loops, edges past the count, a vertex with edges back into the tree,
  // an all-ones row and loads past the count that must be dropped
  task automatic test_graph_corners();
    write_vertex_count(7'd6);
    send_item(row_item(0, 64'h8000_0000_0000_0003));
    idle_gap(1'b1);
    send_item(row_item(1, 64'h0000_0000_0000_0006));
    idle_gap(1'b1);
    send_item(row_item(2, 64'h0000_0000_0000_0008));
    send_item(row_item(3, 64'hFFFF_FFFF_FFFF_FFFF));
    send_item(row_item(4, 64'h0000_0000_0000_0000));
    idle_gap(1'b1);
    send_item(row_item(5, 64'h0000_0000_0000_0011));
    send_item(row_item(40, 64'hFFFF_FFFF_FFFF_FFFF));
    send_item(row_item(63, rand64()));
    idle_gap(1'b1);
    send_item(search_item());
  endtask

  // several white neighbors: the lowest index goes first; a repeat search
  // must restart the colors and the tick counter
  task automatic test_lowest_neighbor();
    write_vertex_count(7'd4);
    send_item(row_item(0, 64'h0000_0000_0000_000E));
    send_item(row_item(1, 64'h0000_0000_0000_0008));
    send_item(row_item(2, 64'h0000_0000_0000_0001));
    send_item(row_item(3, 64'h0000_0000_0000_0000));
    send_item(search_item());
    send_item(search_item());
  endtask

  // phases of well-formed graphs with random content, with stray loads,
  // skipped rows and back-to-back searches mixed in
  task automatic test_random_graphs();
    int               n;
    int               big_runs;
    bit               use_gaps;
    shape_t           shape;
    logic [CFG_W-1:0] cfg_val;
    big_runs = 0;
    while (items_sent < ITEM_TARGET) begin
      if (big_runs < 2 && ($urandom_range(0, 11) == 0 ||
                           (big_runs == 0 && items_sent > 200))) begin
        n = DFST_MAX_VERTICES;
        // first full-size graph is a chain: deepest stack, stamps up to 128
        shape = (big_runs == 0) ? SHAPE_CHAIN : shape_t'($urandom_range(0, 4));
        big_runs++;
      end else begin
        n = ($urandom_range(0, 9) < 2) ? $urandom_range(1, 2) : $urandom_range(3, 12);
        shape = shape_t'($urandom_range(0, 4));
      end
      cfg_val = CFG_W'(n);
      if (n == DFST_MAX_VERTICES && $urandom_range(0, 1)) begin
        cfg_val = CFG_W'($urandom_range(65, 127));
      end
      if (n == 1 && $urandom_range(0, 1)) cfg_val = '0;
      write_vertex_count(cfg_val);
      use_gaps = ($urandom_range(0, 3) != 0);
      for (int r = 0; r < n; r++) begin
        // now and then a row keeps what an earlier graph left there
        if ($urandom_range(0, 9) != 0) begin
          send_item(row_item(r, make_row(shape, r, n)));
          idle_gap(use_gaps);
        end
        if ($urandom_range(0, 99) < 12) begin
          send_item(row_item($urandom_range(0, DFST_MAX_VERTICES - 1), rand64()));
          idle_gap(use_gaps);
        end
      end
      send_item(search_item());
      if ($urandom_range(0, 4) == 0) begin
        idle_gap(use_gaps);
        send_item(search_item());
      end
      idle_gap(use_gaps);
    end
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------

  initial begin
    for (int i = 0; i < DFST_MAX_VERTICES; i++) adj_model[i] = '0;
    vcount_model = DFST_MAX_VERTICES;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_graph();
    test_count_clamp();
    test_graph_corners();
    test_lowest_neighbor();
    test_random_graphs();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && stamps_due.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // hard stop in case the block hangs
  initial begin
    #(LIMIT_NS);
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
